// ===== rtl/indexed_list_engine_macros.svh =====
// Assertion helpers for the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Consequent checked in the same cycle.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ile_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

	localparam int CAPACITY = 16;

	localparam int REQ_W   = 2;
	localparam int POS_W   = 5;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = CNT_W + POS_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_READ   = 2'd1,
		REQ_DELETE = 2'd2
	} req_kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [REQ_W-1:0]   kind;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic [CNT_W-1:0]   count;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/ile_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_engine_macros.svh"

module ile_store (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire ile_pkg::req_t req,
	output ile_pkg::res_t      res
);

	logic [ile_pkg::VALUE_W-1:0] entries_q [ile_pkg::CAPACITY];
	logic [ile_pkg::VALUE_W-1:0] entries_nxt [ile_pkg::CAPACITY];
	logic [ile_pkg::VALUE_W-1:0] ins_src [ile_pkg::CAPACITY];
	logic [ile_pkg::VALUE_W-1:0] del_src [ile_pkg::CAPACITY];
	logic [ile_pkg::CNT_W-1:0]   count_q;
	logic [ile_pkg::CNT_W-1:0]   count_nxt;
	logic [ile_pkg::CMP_W-1:0]   pos_x;
	logic [ile_pkg::CMP_W-1:0]   cnt_x;
	logic [ile_pkg::VALUE_W-1:0] res_value;
	ile_pkg::status_t            res_status;
	logic                        full;
	logic                        do_ins;
	logic                        do_del;

	assign pos_x = {{ile_pkg::CNT_W{1'b0}}, req.pos};
	assign cnt_x = {{ile_pkg::POS_W{1'b0}}, count_q};
	assign full  = (count_q == ile_pkg::CNT_W'(ile_pkg::CAPACITY));

	always_comb begin
		res_value  = '0;
		res_status = ile_pkg::ST_OK;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		unique case (req.kind)
			ile_pkg::REQ_INSERT: begin
				if (pos_x > cnt_x) begin
					res_status = ile_pkg::ST_BADPOS;
				end else if (full) begin
					res_status = ile_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			ile_pkg::REQ_READ: begin
				if (pos_x >= cnt_x) begin
					res_status = ile_pkg::ST_BADPOS;
					res_value  = '1;
				end else begin
					res_value = entries_q[pos_x[ile_pkg::IDX_W-1:0]];
				end
			end
			ile_pkg::REQ_DELETE: begin
				if (count_q == '0) begin
					res_status = ile_pkg::ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					res_status = ile_pkg::ST_BADPOS;
				end else begin
					do_del = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (do_ins) begin
			count_nxt = count_q + 1'b1;
		end else if (do_del) begin
			count_nxt = count_q - 1'b1;
		end else begin
			count_nxt = count_q;
		end
	end

	assign res = '{value: res_value, status: res_status, count: count_nxt};

	// neighbor taps for the parallel shift
	always_comb begin
		ins_src[0] = entries_q[0];
		for (int i = 1; i < ile_pkg::CAPACITY; i++) begin
			ins_src[i] = entries_q[i-1];
		end
		del_src[ile_pkg::CAPACITY-1] = entries_q[ile_pkg::CAPACITY-1];
		for (int i = 0; i < ile_pkg::CAPACITY - 1; i++) begin
			del_src[i] = entries_q[i+1];
		end
	end

	always_comb begin
		for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
			entries_nxt[i] = entries_q[i];
			if (do_ins) begin
				if (ile_pkg::CMP_W'(i) == pos_x) begin
					entries_nxt[i] = req.value;
				end else if (ile_pkg::CMP_W'(i) > pos_x) begin
					entries_nxt[i] = ins_src[i];
				end
			end else if (do_del) begin
				if (ile_pkg::CMP_W'(i) >= pos_x) begin
					entries_nxt[i] = del_src[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && (do_ins || do_del)) begin
			entries_q <= entries_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_nxt;
		end
	end

	`ILE_ASSERT_NOW(a_count_cap, 1'b1, count_q <= ile_pkg::CNT_W'(ile_pkg::CAPACITY), "count above capacity")
	`ILE_ASSERT_NEXT(a_ins_grow, en && do_ins, count_q == $past(count_q) + 1'b1, "insert did not grow count")
	`ILE_ASSERT_NEXT(a_err_hold, en && res.status != ile_pkg::ST_OK, count_q == $past(count_q), "failed request changed count")
	`ILE_ASSERT_NOW(a_bad_read, req.kind == ile_pkg::REQ_READ && res.status != ile_pkg::ST_OK, res.value == '1, "bad read value not all ones")

endmodule

`default_nettype wire

// ===== rtl/ile_outreg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ile_outreg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire ile_pkg::res_t              res,
	input  wire logic                       stall,
	output logic                            valid,
	output logic signed [ile_pkg::VALUE_W-1:0] value_out,
	output logic [ile_pkg::STAT_W-1:0]      status,
	output logic [ile_pkg::COUNT_W-1:0]     count_out
);

	ile_pkg::res_t                                   res_q;
	logic [ile_pkg::CNT_W+ile_pkg::COUNT_W-1:0]      count_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (load) begin
			valid <= 1'b1;
		end else if (!stall) begin
			valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign count_ext = {{ile_pkg::COUNT_W{1'b0}}, res_q.count};
	assign value_out = res_q.value;
	assign status    = res_q.status;
	assign count_out = count_ext[ile_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/indexed_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | ports                               | word
// ---------+-------------------------------------+------------------------------
// in       | in_valid, in_stall                  | req_type, position, value_in
// out      | out_valid, out_stall                | value_out, status, count_out
//
// One word per cycle while out_stall is low; each word is held in req_s1, its result in u_outreg.
// All list shifting happens in parallel across the register array of entries.
// arst_n clears the entry count and both valid flags; entries need no clearing.
// A stalled output backs up into the input register, then raises in_stall.

module indexed_list_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ile_pkg::REQ_W-1:0]     req_type,
	input  wire logic [ile_pkg::POS_W-1:0]     position,
	input  wire logic signed [ile_pkg::VALUE_W-1:0] value_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [ile_pkg::VALUE_W-1:0] value_out,
	output logic [ile_pkg::STAT_W-1:0]         status,
	output logic [ile_pkg::COUNT_W-1:0]        count_out
);

	ile_pkg::req_t req_s1;
	logic          valid_s1;
	logic          adv;
	ile_pkg::res_t res;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.kind  <= req_type;
			req_s1.pos   <= position;
			req_s1.value <= value_in;
		end
	end

	ile_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.req    (req_s1),
		.res    (res)
	);

	ile_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (res),
		.stall     (out_stall),
		.valid     (out_valid),
		.value_out (value_out),
		.status    (status),
		.count_out (count_out)
	);

endmodule

`default_nettype wire

// ===== dv/indexed_list_engine_tb.sv =====
`timescale 1ns / 1ps

module indexed_list_engine_tb;
	import ile_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1500;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_LEN     = 150;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [REQ_W-1:0]          kind;
		logic [POS_W-1:0]          pos;
		logic signed [VALUE_W-1:0] value;
		int                        gap;
		bit                        drain;
	} list_req_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		status_t                   status;
		logic [COUNT_W-1:0]        count;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [REQ_W-1:0] req_type = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [VALUE_W-1:0] value_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [VALUE_W-1:0] value_out;
	logic [STAT_W-1:0] status;
	logic [COUNT_W-1:0] count_out;

	indexed_list_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.position  (position),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_out (value_out),
		.status    (status),
		.count_out (count_out)
	);

	list_req_t   req_backlog[$];
	list_reply_t list_replies[$];

	// shadow list
	logic signed [VALUE_W-1:0] model_vals [CAPACITY];
	int model_len = 0;
	int gen_len = 0;

	bit in_fire = 1'b0;
	bit out_fire = 1'b0;
	int send_gap = 0;
	int words_accepted = 0;
	int replies_checked = 0;
	int mismatches = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int rx_wait = 0;
	bit rx_calm = 1'b0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	list_req_t taken;
	list_req_t next_word;
	list_reply_t want;

	function automatic list_reply_t apply_request(input list_req_t rq);
		list_reply_t rp;
		int i;
		rp.value = '0;
		rp.status = ST_OK;
		case (rq.kind)
			REQ_INSERT: begin
				if (int'(rq.pos) > model_len) begin
					rp.status = ST_BADPOS;
				end else if (model_len >= CAPACITY) begin
					rp.status = ST_FULL;
				end else begin
					for (i = model_len; i > int'(rq.pos); i--)
						model_vals[i] = model_vals[i - 1];
					model_vals[rq.pos] = rq.value;
					model_len++;
				end
			end
			REQ_READ: begin
				if (int'(rq.pos) >= model_len) begin
					rp.status = ST_BADPOS;
					rp.value = -1;
				end else begin
					rp.value = model_vals[rq.pos];
				end
			end
			REQ_DELETE: begin
				if (model_len == 0) begin
					rp.status = ST_EMPTY;
				end else if (int'(rq.pos) >= model_len) begin
					rp.status = ST_BADPOS;
				end else begin
					for (i = int'(rq.pos); i + 1 < model_len; i++)
						model_vals[i] = model_vals[i + 1];
					model_len--;
				end
			end
			default: ;
		endcase
		rp.count = model_len[COUNT_W-1:0];
		return rp;
	endfunction

	task automatic queue_word(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
			input logic signed [VALUE_W-1:0] value, input bit drain);
		list_req_t w;
		int idx;
		idx = req_backlog.size();
		w.kind = kind;
		w.pos = pos;
		w.value = value;
		w.drain = drain;
		// keep offering around the long output hold so the input backs up
		if (idx >= 390 && idx < 470)
			w.gap = $urandom_range(0, 1);
		else if ((idx / 150) % 3 == 1)
			w.gap = 0;
		else
			w.gap = $urandom_range(0, 12);
		req_backlog.push_back(w);
		if (kind == REQ_INSERT && int'(pos) <= gen_len && gen_len < CAPACITY)
			gen_len++;
		else if (kind == REQ_DELETE && int'(pos) < gen_len)
			gen_len--;
	endtask

	// accept side: predict on every accepted word
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire) begin
			taken.kind = req_type;
			taken.pos = position;
			taken.value = value_in;
			list_replies.push_back(apply_request(taken));
			words_accepted++;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_fire)) begin
			if (req_backlog.size() == 0) begin
				in_valid <= 1'b0;
			end else if (send_gap < req_backlog[0].gap) begin
				in_valid <= 1'b0;
				send_gap++;
			end else if (req_backlog[0].drain && list_replies.size() != 0) begin
				in_valid <= 1'b0;
			end else begin
				next_word = req_backlog.pop_front();
				in_valid <= 1'b1;
				req_type <= next_word.kind;
				position <= next_word.pos;
				value_in <= next_word.value;
				send_gap = 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_fire = arst_n && out_valid && !out_stall;
		if (out_fire) begin
			if (list_replies.size() == 0) begin
				$error("unexpected word: value_out %0d status %0d count_out %0d",
					value_out, status, count_out);
				mismatches++;
			end else begin
				want = list_replies.pop_front();
				if (value_out !== want.value) begin
					$error("value_out: expected %0d, actual %0d", want.value, value_out);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					mismatches++;
				end
				if (count_out !== want.count) begin
					$error("count_out: expected %0d, actual %0d", want.count, count_out);
					mismatches++;
				end
				status_seen[want.status]++;
				replies_checked++;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (out_fire) begin
			if (replies_checked % 80 == 0)
				rx_calm = ($urandom_range(0, 2) == 0);
			rx_wait = rx_calm ? 0 : $urandom_range(0, 12);
		end
		if (!hold_done && words_accepted >= HOLD_AT) begin
			hold_left = HOLD_LEN;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("indexed_list_engine_tb failed");
		$finish;
	end

	initial begin
		int n;
		int roll;
		int last;
		bit growing;
		logic [REQ_W-1:0] kind;
		logic [POS_W-1:0] pos;
		logic signed [VALUE_W-1:0] v;

		// empty list corners
		queue_word(REQ_READ, 0, 5, 1'b0);
		queue_word(REQ_DELETE, 0, 0, 1'b0);
		queue_word(REQ_INSERT, 1, 9, 1'b0);
		queue_word(REQ_INSERT, 16, 9, 1'b0);
		queue_word(REQ_UNUSED, 31, -1, 1'b0);
		// head, tail, middle inserts with extreme values
		queue_word(REQ_INSERT, 0, 32'sh8000_0000, 1'b0);
		queue_word(REQ_INSERT, 1, 32'sh7fff_ffff, 1'b0);
		queue_word(REQ_INSERT, 0, -1, 1'b0);
		queue_word(REQ_INSERT, 1, 0, 1'b0);
		queue_word(REQ_READ, 0, 0, 1'b0);
		queue_word(REQ_READ, 3, 0, 1'b0);
		queue_word(REQ_READ, 4, 0, 1'b0);
		queue_word(REQ_READ, 31, 0, 1'b0);
		queue_word(REQ_DELETE, 4, 0, 1'b0);
		queue_word(REQ_DELETE, 1, 0, 1'b0);
		queue_word(REQ_DELETE, 0, 0, 1'b0);
		queue_word(REQ_DELETE, 1, 0, 1'b0);
		queue_word(REQ_DELETE, 0, 0, 1'b0);
		queue_word(REQ_DELETE, 0, 0, 1'b0);
		queue_word(REQ_READ, 0, 0, 1'b0);

		growing = 1'b1;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (gen_len == CAPACITY && $urandom_range(0, 2) == 0)
				growing = 1'b0;
			if (gen_len == 0)
				growing = 1'b1;
			case ($urandom_range(0, 9))
				0: v = 32'sh8000_0000;
				1: v = 32'sh7fff_ffff;
				2: v = -1;
				3: v = 0;
				default: v = $urandom();
			endcase
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				kind = REQ_W'($urandom_range(0, 3));
				pos = POS_W'($urandom_range(0, 31));
			end else begin
				if (roll < 30)
					kind = REQ_READ;
				else if ((roll < 80) == growing)
					kind = REQ_INSERT;
				else
					kind = REQ_DELETE;
				last = (kind == REQ_INSERT) ? gen_len : ((gen_len > 0) ? gen_len - 1 : 0);
				case ($urandom_range(0, 9))
					0, 1: pos = 0;
					2, 3: pos = POS_W'(last);
					4: pos = POS_W'($urandom_range(last + 1, 31));
					default: pos = POS_W'($urandom_range(0, last));
				endcase
			end
			queue_word(kind, pos, v, n == 500 || n == 1100);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() != 0 || in_valid) @(posedge clk);
		while (list_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests sent, %0d words checked, %0d mismatches",
			words_accepted, replies_checked, mismatches);
		$display("status counts: ok %0d, bad position %0d, empty %0d, full %0d",
			status_seen[ST_OK], status_seen[ST_BADPOS], status_seen[ST_EMPTY],
			status_seen[ST_FULL]);
		if (mismatches == 0 && list_replies.size() == 0) begin
			$display("indexed_list_engine_tb passed");
		end else begin
			$display("indexed_list_engine_tb failed");
		end
		$finish;
	end

endmodule
